// File: hdl/three_step_phase_shift_angle_defines.svh
// assertion macros for the three-step phase-shift angle block
// used by the checker file; no other dependencies
`ifndef THREE_STEP_PHASE_SHIFT_ANGLE_DEFINES_SVH
`define THREE_STEP_PHASE_SHIFT_ANGLE_DEFINES_SVH

// same-cycle implication, off during reset
`define TSPS_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsps: implication check failed");

// next-cycle implication, off during reset
`define TSPS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsps: next-cycle check failed");

// condition that must hold in the cycle after reset is seen
`define TSPS_ASSERT_RST(name, clk, rst_n, cons) \
    name: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error("tsps: reset check failed");

`endif

// File: hdl/tsps_pkg.sv
// shared types and constants of the three-step phase-shift angle block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tsps_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ATAN_LEN  = 24;

    // sqrt(3) in q1.16
    localparam logic signed [17:0] SQRT3_Q16 = 18'sd113512;

    // half a turn on the 32-bit angle circle
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;

    // atan(2^-i) on a circle of 2^32 units per turn
    localparam logic [31:0] ATAN_TURN32 [ATAN_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // control travelling with each item down the chain
    typedef struct packed {
        logic valid;
        logic no_mod;
    } t_ctl;

endpackage

`default_nettype wire

// File: hdl/tsps_if.sv
// valid/ready channel interfaces: pixel triple in, phase out
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface tsps_pix_if #(
    parameter int SAMPLE_BITS = 8
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] intensity_a;
    logic [SAMPLE_BITS-1:0] intensity_b;
    logic [SAMPLE_BITS-1:0] intensity_c;

    modport source (output valid, output intensity_a, output intensity_b,
                    output intensity_c, input ready);
    modport sink   (input valid, input intensity_a, input intensity_b,
                    input intensity_c, output ready);
endinterface

interface tsps_phase_if #(
    parameter int ANGLE_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [ANGLE_BITS-1:0] phase_angle;
    logic                         no_modulation;

    modport source (output valid, output phase_angle, output no_modulation,
                    input ready);
    modport sink   (input valid, input phase_angle, input no_modulation,
                    output ready);
endinterface

`default_nettype wire

// File: hdl/three_step_phase_shift_angle.sv
// top level: wrapped phase of three 120-degree shifted samples via cordic
// depends on tsps_pkg, tsps_if, tsps_prep, tsps_cell, tsps_round
//
//   port      dir  item                                        handshake
//   i_pix     in   intensity_a, intensity_b, intensity_c       valid/ready
//   o_phase   out  phase_angle, no_modulation                  valid/ready
//
// one item per clock sustained while o_phase.ready is high; the pipeline holds
// two front-end stages, one cordic cell per micro-rotation and an output register
// ready ripples back stage by stage, so only full stages hold on a stall
// and bubbles in the chain still take new items while a result waits
// reset clears the valid bits only; no other state
`timescale 1ns / 1ps
`default_nettype none

module three_step_phase_shift_angle #(
    parameter int SAMPLE_BITS   = 8,
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tsps_pix_if.sink      i_pix,
    tsps_phase_if.source  o_phase
);

    // headroom for 2b - a - c, 16 fraction bits and cordic gain
    localparam int DW     = SAMPLE_BITS + 20;
    localparam int STAGES = (CORDIC_STAGES > tsps_pkg::ATAN_LEN) ?
                            tsps_pkg::ATAN_LEN : CORDIC_STAGES;

    tsps_pkg::t_ctl       w_ctl [STAGES+1];
    logic                 w_rdy [STAGES+1];
    logic signed [DW-1:0] w_x   [STAGES+1];
    logic signed [DW-1:0] w_y   [STAGES+1];
    logic [31:0]          w_z   [STAGES+1];

    tsps_prep #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DW          (DW)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pix.valid),
        .o_ready (i_pix.ready),
        .i_a     (i_pix.intensity_a),
        .i_b     (i_pix.intensity_b),
        .i_c     (i_pix.intensity_c),
        .o_ctl   (w_ctl[0]),
        .i_ready (w_rdy[0]),
        .o_x     (w_x[0]),
        .o_y     (w_y[0]),
        .o_z     (w_z[0])
    );

    for (genvar g = 0; g < STAGES; g++) begin : g_cell
        tsps_cell #(
            .DW    (DW),
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .o_ready (w_rdy[g]),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_z     (w_z[g]),
            .o_ctl   (w_ctl[g+1]),
            .i_ready (w_rdy[g+1]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_z     (w_z[g+1])
        );
    end

    tsps_round #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_round (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_ctl[STAGES]),
        .o_ready         (w_rdy[STAGES]),
        .i_z             (w_z[STAGES]),
        .o_valid         (o_phase.valid),
        .i_ready         (o_phase.ready),
        .o_phase_angle   (o_phase.phase_angle),
        .o_no_modulation (o_phase.no_modulation)
    );

endmodule

`default_nettype wire

// File: hdl/tsps_prep.sv
// front end: differences, half-turn pre-rotation and sqrt3 scaling
// depends on tsps_pkg
`timescale 1ns / 1ps
`default_nettype none

module tsps_prep #(
    parameter int SAMPLE_BITS = 8,
    parameter int DW          = 28
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [SAMPLE_BITS-1:0]  i_a,
    input  logic [SAMPLE_BITS-1:0]  i_b,
    input  logic [SAMPLE_BITS-1:0]  i_c,
    output tsps_pkg::t_ctl          o_ctl,
    input  logic                    i_ready,
    output logic signed [DW-1:0]    o_x,
    output logic signed [DW-1:0]    o_y,
    output logic [31:0]             o_z
);

    localparam int SB = SAMPLE_BITS;

    logic signed [SB:0]   w_da;
    logic signed [SB+1:0] w_dx;
    logic                 w_neg;
    logic                 w_rdy1;
    logic                 w_rdy2;

    logic                 r1_valid;
    logic signed [SB:0]   r1_d1;
    logic signed [SB+1:0] r1_d2;
    logic                 r1_zero;
    logic                 r1_neg;

    logic                 r2_valid;
    logic                 r2_zero;
    logic signed [DW-1:0] r2_x;
    logic signed [DW-1:0] r2_y;
    logic [31:0]          r2_z;

    logic signed [DW-1:0] n2_x;
    logic signed [DW-1:0] n2_y;

    assign w_rdy2 = !r2_valid || i_ready;
    assign w_rdy1 = !r1_valid || w_rdy2;
    assign o_ready = w_rdy1;

    // a - c and 2b - a - c
    assign w_da  = $signed({1'b0, i_a}) - $signed({1'b0, i_c});
    assign w_dx  = $signed({1'b0, i_b, 1'b0}) - $signed({2'b00, i_a})
                 - $signed({2'b00, i_c});
    assign w_neg = w_dx[SB+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_rdy1) begin
            r1_valid <= i_valid;
        end
    end

    // turn by pi when the denominator is negative
    always_ff @(posedge i_clk) begin
        if (i_valid && w_rdy1) begin
            r1_d1   <= w_neg ? -w_da : w_da;
            r1_d2   <= w_neg ? -w_dx : w_dx;
            r1_zero <= (w_da == '0) && (w_dx == '0);
            r1_neg  <= w_neg;
        end
    end

    assign n2_y = DW'(r1_d1) * DW'(tsps_pkg::SQRT3_Q16);
    assign n2_x = DW'(r1_d2) <<< tsps_pkg::FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_rdy2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r1_valid && w_rdy2) begin
            r2_x    <= n2_x;
            r2_y    <= n2_y;
            r2_z    <= r1_neg ? tsps_pkg::HALF_TURN : '0;
            r2_zero <= r1_zero;
        end
    end

    assign o_ctl.valid  = r2_valid;
    assign o_ctl.no_mod = r2_zero;
    assign o_x = r2_x;
    assign o_y = r2_y;
    assign o_z = r2_z;

endmodule

`default_nettype wire

// File: hdl/tsps_cell.sv
// one cordic vectoring micro-rotation with its own pipeline register
// depends on tsps_pkg
`timescale 1ns / 1ps
`default_nettype none

module tsps_cell #(
    parameter int DW    = 28,
    parameter int STAGE = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tsps_pkg::t_ctl       i_ctl,
    output logic                 o_ready,
    input  logic signed [DW-1:0] i_x,
    input  logic signed [DW-1:0] i_y,
    input  logic [31:0]          i_z,
    output tsps_pkg::t_ctl       o_ctl,
    input  logic                 i_ready,
    output logic signed [DW-1:0] o_x,
    output logic signed [DW-1:0] o_y,
    output logic [31:0]          o_z
);

    logic                 r_valid;
    logic                 r_no_mod;
    logic signed [DW-1:0] r_x;
    logic signed [DW-1:0] r_y;
    logic [31:0]          r_z;

    logic signed [DW-1:0] w_dx;
    logic signed [DW-1:0] w_dy;
    logic                 w_pos;
    logic signed [DW-1:0] n_x;
    logic signed [DW-1:0] n_y;
    logic [31:0]          n_z;

    assign o_ready = !r_valid || i_ready;

    assign w_dx  = i_y >>> STAGE;
    assign w_dy  = i_x >>> STAGE;
    // zero y counts as positive
    assign w_pos = !i_y[DW-1];

    always_comb begin
        if (w_pos) begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_z = i_z + tsps_pkg::ATAN_TURN32[STAGE];
        end else begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_z = i_z - tsps_pkg::ATAN_TURN32[STAGE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid && o_ready) begin
            r_x      <= n_x;
            r_y      <= n_y;
            r_z      <= n_z;
            r_no_mod <= i_ctl.no_mod;
        end
    end

    assign o_ctl.valid  = r_valid;
    assign o_ctl.no_mod = r_no_mod;
    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

`default_nettype wire

// File: hdl/tsps_round.sv
// output register: rounds the 32-bit angle to the result width
// depends on tsps_pkg
`timescale 1ns / 1ps
`default_nettype none

module tsps_round #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tsps_pkg::t_ctl               i_ctl,
    output logic                         o_ready,
    input  logic [31:0]                  i_z,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [ANGLE_BITS-1:0] o_phase_angle,
    output logic                         o_no_modulation
);

    localparam logic [31:0] ROUND_ADD = 32'd1 << (31 - ANGLE_BITS);

    logic                         r_valid;
    logic signed [ANGLE_BITS-1:0] r_phase;
    logic                         r_no_mod;
    logic [31:0]                  w_sum;

    assign o_ready = !r_valid || i_ready;

    // round half up, wraps past +pi to -pi
    assign w_sum = i_z + ROUND_ADD;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid && o_ready) begin
            r_phase  <= i_ctl.no_mod ? '0 : $signed(w_sum[31 -: ANGLE_BITS]);
            r_no_mod <= i_ctl.no_mod;
        end
    end

    assign o_valid         = r_valid;
    assign o_phase_angle   = r_phase;
    assign o_no_modulation = r_no_mod;

endmodule

`default_nettype wire

// File: hdl/tsps_checker.sv
// port-level checks on the phase block, bound to the top level
// depends on three_step_phase_shift_angle_defines.svh and the top level
`timescale 1ns / 1ps
`default_nettype none
`include "three_step_phase_shift_angle_defines.svh"

module tsps_checker #(
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         i_in_ready,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic signed [ANGLE_BITS-1:0] i_phase_angle,
    input wire logic                         i_no_modulation
);

    // every pipeline register can hold one item
    localparam int CAP   = CORDIC_STAGES + 3;
    localparam int CNT_W = $clog2(CAP + 1) + 1;

    logic             w_in_acc;
    logic             w_out_acc;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;
    assign n_count   = r_count + CNT_W'(w_in_acc) - CNT_W'(w_out_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    `TSPS_ASSERT_IMPL(a_nomod_zero, i_clk, i_rst_n, i_out_valid && i_no_modulation, i_phase_angle == '0)
    `TSPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_phase_angle) && $stable(i_no_modulation))
    `TSPS_ASSERT_IMPL(a_out_has_item, i_clk, i_rst_n, w_out_acc, r_count != '0)
    `TSPS_ASSERT_IMPL(a_occupancy, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAP))
    `TSPS_ASSERT_RST(a_rst_clear, i_clk, i_rst_n, !i_out_valid)

endmodule

bind three_step_phase_shift_angle tsps_checker #(
    .ANGLE_BITS    (ANGLE_BITS),
    .CORDIC_STAGES (CORDIC_STAGES)
) u_tsps_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_pix.valid),
    .i_in_ready      (i_pix.ready),
    .i_out_valid     (o_phase.valid),
    .i_out_ready     (o_phase.ready),
    .i_phase_angle   (o_phase.phase_angle),
    .i_no_modulation (o_phase.no_modulation)
);

`default_nettype wire

// File: tb/three_step_phase_shift_angle_tb.sv
// testbench of the three-step phase-shift angle block: random and directed pixel items
// needs tsps_if and the block with its own sources; checks each phase against a local model
`timescale 1ns / 1ps

module three_step_phase_shift_angle_tb;

    localparam int CORDIC_STAGES = 16;
    localparam int LATENCY       = CORDIC_STAGES + 3;
    localparam longint SQRT3_Q16 = 113512;

    // atan(2^-i) on a 2^32 circle
    localparam logic [31:0] ROT_ANGLE [CORDIC_STAGES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861
    };

    // {a, b, c}
    localparam int N_DIRECTED = 23;
    localparam logic [23:0] DIRECTED [N_DIRECTED] = '{
        24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000, 24'h00FF00, 24'h0000FF,
        24'hFFFF00, 24'hFF00FF, 24'h00FFFF, 24'h0AC80A, 24'hC80AC8, 24'h007FFE,
        24'hFE7F00, 24'h650064, 24'h640065, 24'h010000, 24'h000001, 24'h80FF80,
        24'hFF8000, 24'h55AA55, 24'hAA55AA, 24'h010100, 24'h000101
    };

    typedef struct {
        logic signed [15:0] angle;
        logic               no_mod;
    } t_phase_item;

    class phase_scoreboard;
        t_phase_item expected_q[$];
        int errors;
        int n_pix;
        int n_checked;
        int n_flat;
        int n_half_turn;

        function new();
            errors = 0;
            n_pix = 0;
            n_checked = 0;
            n_flat = 0;
            n_half_turn = 0;
        endfunction

        function t_phase_item predict_phase(input logic [7:0] a, b, c);
            t_phase_item r;
            longint sx, sy, dx, dy;
            logic [31:0] z, rnd;
            sy = (longint'(a) - longint'(c)) * SQRT3_Q16;
            sx = (2 * longint'(b) - longint'(a) - longint'(c)) * 65536;
            z = 32'd0;
            r.angle = '0;
            r.no_mod = 1'b1;
            if (sx == 0 && sy == 0)
                return r;
            // left half plane: turn by pi first
            if (sx < 0) begin
                sx = -sx;
                sy = -sy;
                z = 32'h8000_0000;
            end
            for (int i = 0; i < CORDIC_STAGES; i++) begin
                dx = sy >>> i;
                dy = sx >>> i;
                if (sy >= 0) begin
                    sx = sx + dx;
                    sy = sy - dy;
                    z = z + ROT_ANGLE[i];
                end else begin
                    sx = sx - dx;
                    sy = sy + dy;
                    z = z - ROT_ANGLE[i];
                end
            end
            rnd = z + 32'h0000_8000;
            r.angle = rnd[31:16];
            r.no_mod = 1'b0;
            return r;
        endfunction

        function void note_pix(input logic [7:0] a, b, c);
            expected_q.push_back(predict_phase(a, b, c));
            n_pix++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(input string what, input int got, input int want);
            $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
                     n_checked);
            errors++;
        endtask

        task check_phase(input logic signed [15:0] angle, input logic no_mod);
            t_phase_item e;
            if (expected_q.size() == 0) begin
                report("unexpected result", int'(angle), 0);
                return;
            end
            e = expected_q.pop_front();
            if (angle !== e.angle)
                report("phase_angle", int'(angle), int'(e.angle));
            if (no_mod !== e.no_mod)
                report("no_modulation", int'(no_mod), int'(e.no_mod));
            if (e.no_mod)
                n_flat++;
            if (e.angle == -16'sd32768)
                n_half_turn++;
            n_checked++;
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    tsps_pix_if   #(.SAMPLE_BITS(8)) pix_if ();
    tsps_phase_if #(.ANGLE_BITS(16)) phase_if ();

    three_step_phase_shift_angle #(
        .SAMPLE_BITS  (8),
        .ANGLE_BITS   (16),
        .CORDIC_STAGES(CORDIC_STAGES)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix_if.sink),
        .o_phase(phase_if.source)
    );

    phase_scoreboard sb = new();

    int  src_idle_pct = 15;
    int  snk_idle_pct = 46;
    logic hold_tog = 1'b0;

    always #1 i_clk = ~i_clk;

    // monitors sample the values seen at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && pix_if.valid && pix_if.ready)
            sb.note_pix(pix_if.intensity_a, pix_if.intensity_b, pix_if.intensity_c);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && phase_if.valid && phase_if.ready)
            sb.check_phase(phase_if.phase_angle, phase_if.no_modulation);
    end

    // receiver: random back-pressure, plus a long hold-off on request
    initial begin : receiver
        int   hold_left;
        logic seen_tog;
        hold_left = 0;
        seen_tog = 1'b0;
        phase_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_tog != seen_tog) begin
                seen_tog = hold_tog;
                hold_left = 150;
            end
            if (!i_rst_n) begin
                phase_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                phase_if.ready <= 1'b0;
                hold_left--;
            end else begin
                phase_if.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // valid stays high between back-to-back items, lowered only for a gap
    task automatic send_pix(input logic [7:0] a, b, c);
        if ($urandom_range(99) < src_idle_pct) begin
            pix_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        pix_if.valid       <= 1'b1;
        pix_if.intensity_a <= a;
        pix_if.intensity_b <= b;
        pix_if.intensity_c <= c;
        do @(posedge i_clk); while (!pix_if.ready);
    endtask

    task automatic send_random(input int n, input int hold_at);
        logic [7:0] a, b, c;
        int sum;
        for (int k = 0; k < n; k++) begin
            a = 8'($urandom_range(255));
            b = 8'($urandom_range(255));
            c = 8'($urandom_range(255));
            case ($urandom_range(9))
                0: begin
                    b = a;
                    c = a;
                end
                1: c = a;
                2: begin
                    // zero denominator: 2b == a + c
                    c = {7'($urandom_range(127)), a[0]};
                    sum = int'(a) + int'(c);
                    b = 8'(sum / 2);
                end
                3: begin
                    // dark second sample, a and c close: phase near pi
                    b = 8'($urandom_range(3));
                    c = 8'(int'(a) + $urandom_range(2) - 1);
                end
                default: ;
            endcase
            if (k == hold_at)
                hold_tog <= ~hold_tog;
            send_pix(a, b, c);
        end
    endtask

    task automatic wait_all_results();
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    initial begin : main
        i_rst_n            <= 1'b0;
        pix_if.valid       <= 1'b0;
        pix_if.intensity_a <= '0;
        pix_if.intensity_b <= '0;
        pix_if.intensity_c <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct = 15;
        snk_idle_pct = 46;
        for (int k = 0; k < N_DIRECTED; k++)
            send_pix(DIRECTED[k][23:16], DIRECTED[k][15:8], DIRECTED[k][7:0]);
        send_random(260, 100);
        wait_all_results();

        src_idle_pct = 46;
        snk_idle_pct = 15;
        send_random(260, -1);
        wait_all_results();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        send_random(260, 130);
        wait_all_results();

        repeat (LATENCY + 8) @(posedge i_clk);
        $display("covered %0d pixel items with %0d results checked", sb.n_pix, sb.n_checked);
        $display("including %0d flat pixels and %0d half-turn angles", sb.n_flat,
                 sb.n_half_turn);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : watchdog
        #400000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/tsps_pkg.sv
hdl/tsps_if.sv
hdl/tsps_prep.sv
hdl/tsps_cell.sv
hdl/tsps_round.sv
hdl/three_step_phase_shift_angle.sv
hdl/tsps_checker.sv
tb/three_step_phase_shift_angle_tb.sv
